### sv/pcps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcps_pkg;

    localparam int QW = 24;
    localparam int WW = 52;

    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [WW-1:0] wide_t;

    typedef enum logic [1:0] {
        REG_COL_PHASE_A = 2'd0,
        REG_COL_PHASE_B = 2'd1,
        REG_CAM_HEIGHT  = 2'd2,
        REG_CUBE_MODE   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic signed [13:0] tc;
        logic signed [13:0] ts;
        logic signed [13:0] sc;
        logic signed [13:0] ss;
        logic               hit_en;
        logic signed [9:0]  plasma;
    } carry_t;

    typedef struct packed {
        q_t px;
        q_t py;
        q_t pz;
    } pos_t;

    localparam wide_t Q_MAX = 52'sd8388607;
    localparam wide_t Q_MIN = -52'sd8388608;

    localparam q_t PZ_INIT  = 24'sd209716;
    localparam q_t PZS_INIT = -24'sd183500;
    localparam wide_t BOX_Z  = 52'sd393216;
    localparam wide_t BOX_SZ = 52'sd176947;
    localparam logic signed [17:0] DZ = 18'sd52429;

    function automatic q_t sat_q(input wide_t v);
        q_t r;
        if (v > Q_MAX) begin
            r = q_t'(Q_MAX);
        end else if (v < Q_MIN) begin
            r = q_t'(Q_MIN);
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    function automatic logic [QW:0] abs_q(input q_t v);
        logic signed [QW:0] e;
        e = {v[QW-1], v};
        return (e < 0) ? (-e) : e;
    endfunction

endpackage

`default_nettype wire

### sv/plasma_cube_pixel_shader_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Word fields (low bit first)
// s_axis    in   column, x_coord, y_coord, row_phase_a, row_phase_b,
//                rot_cos, rot_sin, rot_slow_cos, rot_slow_sin
// m_axis    out  shade
// cfg       in   column_phase_a, column_phase_b, camera_height, cube_mode
//
// One word per cycle unless m_tready stalls the output. Pipeline from accept to m_tvalid:
// four front stages after input capture (index reduction, ROM read, plasma),
// five stages per march step (two MAC layers, distance, scale, update), three
// on the last step, and the output register.
// aresetn is synchronous; it clears valid bits and config registers, but sets cube_mode to 1.
// All stages advance together when the output register is free or taken.

module plasma_cube_pixel_shader_core #(
    parameter int TABLE_SIZE  = 512,
    parameter int MARCH_STEPS = 3
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // column, x_coord, y_coord, row_phase_a, row_phase_b, rot_cos, rot_sin,
    // rot_slow_cos, rot_slow_sin, zero pad
    input  wire logic [111:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // shade, zero pad
    output logic [15:0]        m_tdata
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int RW = 17;
    localparam longint RECIP = (64'd1 << 32) / TABLE_SIZE;
    localparam int CW = $clog2(RECIP + 1);
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [11:0] rom_t [TABLE_SIZE];
    typedef longint div_t [8];
    localparam div_t Divs = '{1, 6, 20, 42, 72, 110, 156, 210};

    function automatic logic signed [11:0] quarter_sin(input longint r);
        longint xv;
        longint term;
        longint acc;
        if (r == 0) return 12'sd0;
        if (r >= TABLE_SIZE) return 12'sd1024;
        xv = (r * HALF_PI_Q30) / TABLE_SIZE;
        term = xv;
        acc = xv;
        for (int k = 1; k <= 7; k++) begin
            term = (term * xv) >>> 30;
            term = (term * xv) >>> 30;
            term = term / Divs[k];
            if (k % 2 == 1) acc = acc - term;
            else acc = acc + term;
        end
        if (acc < 0) acc = 0;
        return 12'(acc >>> 20);
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        longint q;
        longint r;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            q = (4 * i) / TABLE_SIZE;
            r = (4 * i) % TABLE_SIZE;
            if (q == 0) t[i] = quarter_sin(r);
            else if (q == 1) t[i] = quarter_sin(TABLE_SIZE - r);
            else if (q == 2) t[i] = -quarter_sin(r);
            else t[i] = -quarter_sin(TABLE_SIZE - r);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // config
    logic [15:0]        cpa_reg;
    logic [15:0]        cpb_reg;
    logic signed [12:0] cam_reg;
    logic               cube_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpa_reg  <= '0;
            cpb_reg  <= '0;
            cam_reg  <= '0;
            cube_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (pcps_pkg::reg_idx_t'(cfg_index))
                pcps_pkg::REG_COL_PHASE_A: cpa_reg  <= cfg_data;
                pcps_pkg::REG_COL_PHASE_B: cpb_reg  <= cfg_data;
                pcps_pkg::REG_CAM_HEIGHT:  cam_reg  <= cfg_data[12:0];
                pcps_pkg::REG_CUBE_MODE:   cube_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    logic m_tvalid_reg;
    logic signed [9:0] shade_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, shade_reg};

    // front stage 0: input capture
    logic          f0_v_reg;
    logic [111:0]  f0_d_reg;

    // front stage 1: raw indices, reciprocal estimate, march start point
    logic                  f1_v_reg;
    logic [RW-1:0]         f1_raw_reg [4];
    logic [RW-1:0]         f1_q_reg [4];
    pcps_pkg::carry_t      f1_c_reg;
    pcps_pkg::pos_t        f1_pos_reg;
    logic [RW-1:0]         f1_raw_next [4];
    logic [RW-1:0]         f1_q_next [4];
    logic [RW+CW-1:0]      prod_q [4];
    pcps_pkg::carry_t      f1_c_next;
    pcps_pkg::pos_t        f1_pos_next;

    // front stage 2: table indices
    logic                  f2_v_reg;
    logic [IW-1:0]         f2_idx_reg [4];
    logic [IW-1:0]         f2_idx_next [4];
    logic signed [RW+1:0]  rem [4];
    pcps_pkg::carry_t      f2_c_reg;
    pcps_pkg::pos_t        f2_pos_reg;

    // front stage 3: ROM reads
    logic                  f3_v_reg;
    logic signed [11:0]    f3_sin_reg [4];
    pcps_pkg::carry_t      f3_c_reg;
    pcps_pkg::pos_t        f3_pos_reg;

    // front stage 4: plasma
    logic                  f4_v_reg;
    pcps_pkg::carry_t      f4_c_reg;
    pcps_pkg::carry_t      f4_c_next;
    pcps_pkg::pos_t        f4_pos_reg;
    logic signed [13:0]    psum;
    logic signed [10:0]    pshift;
    logic signed [9:0]     plasma_next;

    always_comb begin
        f1_c_next.x      = f0_d_reg[22:9];
        f1_c_next.y      = f0_d_reg[36:23];
        f1_c_next.tc     = f0_d_reg[68:55];
        f1_c_next.ts     = f0_d_reg[82:69];
        f1_c_next.sc     = f0_d_reg[96:83];
        f1_c_next.ss     = f0_d_reg[110:97];
        f1_c_next.hit_en = cube_reg && ($signed(f0_d_reg[22:9]) > -14'sd4096)
                           && ($signed(f0_d_reg[22:9]) < 14'sd4096);
        f1_c_next.plasma = '0;
        f1_pos_next.px   = pcps_pkg::q_t'($signed({f0_d_reg[22:9], 6'd0}));
        f1_pos_next.py   = pcps_pkg::q_t'($signed({cam_reg, 4'd0}))
                         + pcps_pkg::q_t'($signed({f0_d_reg[36:23], 6'd0}));
        f1_pos_next.pz   = pcps_pkg::PZ_INIT;
        f1_raw_next[0] = RW'(cpa_reg) + RW'(5) + RW'(f0_d_reg[8:0]) * RW'(5);
        f1_raw_next[1] = RW'(cpb_reg) + RW'(3) + RW'(f0_d_reg[8:0]) * RW'(3);
        f1_raw_next[2] = RW'(f0_d_reg[45:37]);
        f1_raw_next[3] = RW'(f0_d_reg[54:46]);
        for (int i = 0; i < 4; i++) begin
            prod_q[i]    = (RW+CW)'(f1_raw_next[i]) * (RW+CW)'(RECIP);
            f1_q_next[i] = RW'(prod_q[i] >> 32);
        end
        for (int i = 0; i < 4; i++) begin
            rem[i] = $signed({2'b00, f1_raw_reg[i]})
                   - $signed({2'b00, f1_q_reg[i]}) * (RW+2)'(TABLE_SIZE);
            if (rem[i] >= (RW+2)'(TABLE_SIZE)) begin
                rem[i] = rem[i] - (RW+2)'(TABLE_SIZE);
            end
            f2_idx_next[i] = rem[i][IW-1:0];
        end
        psum = 14'(f3_sin_reg[0]) + 14'(f3_sin_reg[1])
             + 14'(f3_sin_reg[2]) + 14'(f3_sin_reg[3]);
        pshift = 11'(psum >>> 3);
        if (pshift > 11'sd511) plasma_next = 10'sd511;
        else if (pshift < -11'sd512) plasma_next = -10'sd512;
        else plasma_next = pshift[9:0];
        f4_c_next = f3_c_reg;
        f4_c_next.plasma = plasma_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_v_reg <= 1'b0;
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
            f4_v_reg <= 1'b0;
        end else if (en) begin
            f0_v_reg <= s_tvalid;
            f1_v_reg <= f0_v_reg;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
            f4_v_reg <= f3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f0_d_reg   <= s_tdata;
            f1_raw_reg <= f1_raw_next;
            f1_q_reg   <= f1_q_next;
            f1_c_reg   <= f1_c_next;
            f1_pos_reg <= f1_pos_next;
            f2_idx_reg <= f2_idx_next;
            f2_c_reg   <= f1_c_reg;
            f2_pos_reg <= f1_pos_reg;
            for (int i = 0; i < 4; i++) begin
                f3_sin_reg[i] <= SINE_ROM[f2_idx_reg[i]];
            end
            f3_c_reg   <= f2_c_reg;
            f3_pos_reg <= f2_pos_reg;
            f4_c_reg   <= f4_c_next;
            f4_pos_reg <= f3_pos_reg;
        end
    end

    // march steps
    logic               st_v   [MARCH_STEPS];
    pcps_pkg::carry_t   st_c   [MARCH_STEPS];
    pcps_pkg::pos_t     st_pos [MARCH_STEPS];
    pcps_pkg::q_t       st_pzs [MARCH_STEPS];

    logic               a_v_reg [MARCH_STEPS];
    pcps_pkg::carry_t   a_c_reg [MARCH_STEPS];
    pcps_pkg::pos_t     a_pos_reg [MARCH_STEPS];
    pcps_pkg::q_t       a_ax_reg [MARCH_STEPS];
    pcps_pkg::q_t       a_az_reg [MARCH_STEPS];

    logic               b_v_reg [MARCH_STEPS];
    pcps_pkg::carry_t   b_c_reg [MARCH_STEPS];
    pcps_pkg::pos_t     b_pos_reg [MARCH_STEPS];
    pcps_pkg::q_t       b_bx_reg [MARCH_STEPS];
    pcps_pkg::q_t       b_by_reg [MARCH_STEPS];
    pcps_pkg::q_t       b_az_reg [MARCH_STEPS];

    logic               c_v_reg [MARCH_STEPS];
    pcps_pkg::carry_t   c_c_reg [MARCH_STEPS];
    pcps_pkg::pos_t     c_pos_reg [MARCH_STEPS];
    pcps_pkg::q_t       c_d_reg [MARCH_STEPS];
    pcps_pkg::q_t       c_s_reg [MARCH_STEPS];

    logic               d_v_reg [MARCH_STEPS];
    pcps_pkg::carry_t   d_c_reg [MARCH_STEPS];
    pcps_pkg::pos_t     d_pos_reg [MARCH_STEPS];
    pcps_pkg::q_t       d_mx_reg [MARCH_STEPS];
    pcps_pkg::q_t       d_my_reg [MARCH_STEPS];
    pcps_pkg::q_t       d_mz_reg [MARCH_STEPS];

    logic               e_v_reg [MARCH_STEPS];
    pcps_pkg::carry_t   e_c_reg [MARCH_STEPS];
    pcps_pkg::pos_t     e_pos_reg [MARCH_STEPS];
    pcps_pkg::q_t       e_pzs_reg [MARCH_STEPS];

    for (genvar k = 0; k < MARCH_STEPS; k++) begin : g_step
        logic signed [17:0] tc18, ts18, sc18, ss18;
        pcps_pkg::q_t ax_next, az_next, bx_next, by_next, d_next, s_next;
        logic [pcps_pkg::QW:0] abx, aby, abz, mmax;

        if (k == 0) begin : g_first
            always_comb begin
                st_v[k]   = f4_v_reg;
                st_c[k]   = f4_c_reg;
                st_pos[k] = f4_pos_reg;
                st_pzs[k] = pcps_pkg::PZS_INIT;
            end
        end else begin : g_next
            always_comb begin
                st_v[k]   = e_v_reg[k-1];
                st_c[k]   = e_c_reg[k-1];
                st_pos[k] = e_pos_reg[k-1];
                st_pzs[k] = e_pzs_reg[k-1];
            end
        end

        always_comb begin
            tc18 = $signed({st_c[k].tc, 4'd0});
            ts18 = $signed({st_c[k].ts, 4'd0});
            ax_next = pcps_pkg::sat_q((pcps_pkg::WW'(ts18 * st_pos[k].px)
                    + pcps_pkg::WW'(tc18 * st_pzs[k])) >>> 16);
            az_next = pcps_pkg::sat_q((pcps_pkg::WW'(tc18 * st_pos[k].px)
                    - pcps_pkg::WW'(ts18 * st_pzs[k])) >>> 16);
            sc18 = $signed({a_c_reg[k].sc, 4'd0});
            ss18 = $signed({a_c_reg[k].ss, 4'd0});
            by_next = pcps_pkg::sat_q((pcps_pkg::WW'(ss18 * a_pos_reg[k].py)
                    + pcps_pkg::WW'(sc18 * a_ax_reg[k])) >>> 16);
            bx_next = pcps_pkg::sat_q((pcps_pkg::WW'(sc18 * a_pos_reg[k].py)
                    - pcps_pkg::WW'(ss18 * a_ax_reg[k])) >>> 16);
            abx = pcps_pkg::abs_q(b_bx_reg[k]);
            aby = pcps_pkg::abs_q(b_by_reg[k]);
            abz = pcps_pkg::abs_q(b_az_reg[k]);
            mmax = (aby > abz) ? aby : abz;
            mmax = (abx > mmax) ? abx : mmax;
            d_next = pcps_pkg::sat_q(pcps_pkg::WW'(mmax) - pcps_pkg::BOX_SZ);
            s_next = pcps_pkg::sat_q((pcps_pkg::WW'(d_next) * 52'sd5) >>> 1);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                a_v_reg[k] <= 1'b0;
                b_v_reg[k] <= 1'b0;
                c_v_reg[k] <= 1'b0;
            end else if (en) begin
                a_v_reg[k] <= st_v[k];
                b_v_reg[k] <= a_v_reg[k];
                c_v_reg[k] <= b_v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_c_reg[k]   <= st_c[k];
                a_pos_reg[k] <= st_pos[k];
                a_ax_reg[k]  <= ax_next;
                a_az_reg[k]  <= az_next;
                b_c_reg[k]   <= a_c_reg[k];
                b_pos_reg[k] <= a_pos_reg[k];
                b_bx_reg[k]  <= bx_next;
                b_by_reg[k]  <= by_next;
                b_az_reg[k]  <= a_az_reg[k];
                c_c_reg[k]   <= b_c_reg[k];
                c_pos_reg[k] <= b_pos_reg[k];
                c_d_reg[k]   <= d_next;
                c_s_reg[k]   <= s_next;
            end
        end

        if (k < MARCH_STEPS - 1) begin : g_update
            logic signed [17:0] bx18, by18;
            pcps_pkg::q_t mx_next, my_next, mz_next;
            pcps_pkg::pos_t pos_next;
            pcps_pkg::q_t pzs_next;

            always_comb begin
                bx18 = $signed({c_c_reg[k].x, 4'd0});
                by18 = $signed({c_c_reg[k].y, 4'd0});
                mx_next = pcps_pkg::sat_q(pcps_pkg::WW'(bx18 * c_s_reg[k]) >>> 16);
                my_next = pcps_pkg::sat_q(pcps_pkg::WW'(by18 * c_s_reg[k]) >>> 16);
                mz_next = pcps_pkg::sat_q(
                    pcps_pkg::WW'(pcps_pkg::DZ * c_s_reg[k]) >>> 16);
                pos_next.px = pcps_pkg::sat_q(pcps_pkg::WW'(d_pos_reg[k].px)
                            + pcps_pkg::WW'(d_mx_reg[k]));
                pos_next.py = pcps_pkg::sat_q(pcps_pkg::WW'(d_pos_reg[k].py)
                            + pcps_pkg::WW'(d_my_reg[k]));
                pos_next.pz = pcps_pkg::sat_q(pcps_pkg::WW'(d_pos_reg[k].pz)
                            + pcps_pkg::WW'(d_mz_reg[k]));
                pzs_next = pcps_pkg::sat_q(pcps_pkg::WW'(pos_next.pz)
                         - pcps_pkg::BOX_Z);
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    d_v_reg[k] <= 1'b0;
                    e_v_reg[k] <= 1'b0;
                end else if (en) begin
                    d_v_reg[k] <= c_v_reg[k];
                    e_v_reg[k] <= d_v_reg[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    d_c_reg[k]   <= c_c_reg[k];
                    d_pos_reg[k] <= c_pos_reg[k];
                    d_mx_reg[k]  <= mx_next;
                    d_my_reg[k]  <= my_next;
                    d_mz_reg[k]  <= mz_next;
                    e_c_reg[k]   <= d_c_reg[k];
                    e_pos_reg[k] <= pos_next;
                    e_pzs_reg[k] <= pzs_next;
                end
            end
        end
    end

    // shade and output register
    localparam int LS = MARCH_STEPS - 1;
    logic [16:0]        cv;
    logic [24:0]        cprod;
    logic [8:0]         cube_shade;
    logic signed [9:0]  shade_next;

    always_comb begin
        if (c_d_reg[LS] <= 0) cv = '0;
        else if (c_d_reg[LS] >= 24'sd16384) cv = 17'd65536;
        else cv = 17'(c_d_reg[LS]) << 2;
        cprod = 25'(cv) * 25'd255;
        cube_shade = 9'd255 - 9'(cprod >> 16);
        if (c_c_reg[LS].hit_en && (cube_shade != 9'd0)) shade_next = 10'(cube_shade);
        else shade_next = c_c_reg[LS].plasma;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= c_v_reg[LS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            shade_reg <= shade_next;
        end
    end

endmodule

`default_nettype wire
